FILE: rtl/core/tdf_pkg.sv
// ----------------------------------------------------------------------------
// tdf_pkg
// Shared constants, codes and controller/datapath handshake types for the
// trail distance follower.
// ----------------------------------------------------------------------------
`default_nettype none

package tdf_pkg;

   // ring geometry
   localparam int TRAIL_DEPTH = 64;
   localparam int IDX_W       = $clog2(TRAIL_DEPTH);
   localparam int CNT_W       = $clog2(TRAIL_DEPTH + 1);

   // trail distance register
   localparam int DIST_W = 6;
   localparam logic [DIST_W-1:0] DIST_RESET = 6'd16;
   localparam logic REG_TRAIL_DISTANCE = 1'b0;

   // interpolation divider: quotient never exceeds the distance
   localparam int COORD_W = 16;
   localparam int MAG_W   = COORD_W + 1;
   localparam int QUOT_W  = DIST_W;
   localparam int NUM_W   = MAG_W + DIST_W;
   localparam int STEP_W  = $clog2(QUOT_W);

   // direction codes
   localparam logic [1:0] FACE_SOUTH = 2'd0;
   localparam logic [1:0] FACE_NORTH = 2'd1;
   localparam logic [1:0] FACE_WEST  = 2'd2;
   localparam logic [1:0] FACE_EAST  = 2'd3;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_CAPTURE,
      OP_LOG_RD,
      OP_LOG_WR,
      OP_SEED_A,
      OP_SEED_B,
      OP_WALK_RD,
      OP_WALK_NEW,
      OP_WALK_ISSUE,
      OP_WALK_SEG,
      OP_WALK_TEST,
      OP_MUL_X,
      OP_DIV_X,
      OP_MUL_Y,
      OP_DIV_Y,
      OP_FINISH
   } op_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic lead_valid;
      logic trail_empty;
      logic same_point;
      logic jump;
      logic walk_done;
      logic hit;
      logic div_last;
      logic out_free;
   } status_type;

   // magnitude of a 16-bit two's complement value
   function automatic logic [MAG_W-1:0] mag16(input logic [COORD_W-1:0] v);
      logic [MAG_W-1:0] ext;
      ext = {v[COORD_W-1], v};
      return v[COORD_W-1] ? (MAG_W'(0) - ext) : ext;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/core/tdf_ctrl.sv
// ----------------------------------------------------------------------------
// tdf_ctrl
// Sequencer: steps one item through logging, ring walk and interpolation.
// ----------------------------------------------------------------------------
`default_nettype none

module tdf_ctrl (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   output logic                req_ready,
   input  tdf_pkg::status_type status,
   output tdf_pkg::cmd_type    cmd
);

   typedef enum logic [4:0] {
      S_IDLE,
      S_START,
      S_LOG_RD,
      S_LOG_CHK,
      S_LOG_WR,
      S_SEED_A,
      S_SEED_B,
      S_WALK_RD,
      S_WALK_NEW,
      S_WALK_ISSUE,
      S_WALK_SEG,
      S_WALK_TEST,
      S_MUL_X,
      S_DIV_X,
      S_MUL_Y,
      S_DIV_Y,
      S_FINISH
   } state_type;

   state_type state_ff, state_in;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_START;
         end
         S_START: begin
            if (!status.lead_valid)      state_in = S_FINISH;
            else if (status.trail_empty) state_in = S_SEED_A;
            else                         state_in = S_LOG_RD;
         end
         S_LOG_RD:  state_in = S_LOG_CHK;
         S_LOG_CHK: begin
            if (status.same_point) state_in = S_WALK_RD;
            else if (status.jump)  state_in = S_SEED_A;
            else                   state_in = S_LOG_WR;
         end
         S_LOG_WR:     state_in = S_WALK_RD;
         S_SEED_A:     state_in = S_SEED_B;
         S_SEED_B:     state_in = S_WALK_RD;
         S_WALK_RD:    state_in = S_WALK_NEW;
         S_WALK_NEW:   state_in = S_WALK_ISSUE;
         S_WALK_ISSUE: state_in = status.walk_done ? S_FINISH : S_WALK_SEG;
         S_WALK_SEG:   state_in = S_WALK_TEST;
         S_WALK_TEST:  state_in = status.hit ? S_MUL_X : S_WALK_ISSUE;
         S_MUL_X:      state_in = S_DIV_X;
         S_DIV_X: begin
            if (status.div_last) state_in = S_MUL_Y;
         end
         S_MUL_Y:      state_in = S_DIV_Y;
         S_DIV_Y: begin
            if (status.div_last) state_in = S_FINISH;
         end
         S_FINISH: begin
            if (status.out_free) state_in = S_IDLE;
         end
         default:      state_in = S_IDLE;
      endcase
   end

   // hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);

   // decode command
   always_comb begin
      cmd.op = tdf_pkg::OP_NONE;
      case (state_ff)
         S_IDLE:       if (req_valid) cmd.op = tdf_pkg::OP_CAPTURE;
         S_LOG_RD:     cmd.op = tdf_pkg::OP_LOG_RD;
         S_LOG_WR:     cmd.op = tdf_pkg::OP_LOG_WR;
         S_SEED_A:     cmd.op = tdf_pkg::OP_SEED_A;
         S_SEED_B:     cmd.op = tdf_pkg::OP_SEED_B;
         S_WALK_RD:    cmd.op = tdf_pkg::OP_WALK_RD;
         S_WALK_NEW:   cmd.op = tdf_pkg::OP_WALK_NEW;
         S_WALK_ISSUE: cmd.op = tdf_pkg::OP_WALK_ISSUE;
         S_WALK_SEG:   cmd.op = tdf_pkg::OP_WALK_SEG;
         S_WALK_TEST:  cmd.op = tdf_pkg::OP_WALK_TEST;
         S_MUL_X:      cmd.op = tdf_pkg::OP_MUL_X;
         S_DIV_X:      cmd.op = tdf_pkg::OP_DIV_X;
         S_MUL_Y:      cmd.op = tdf_pkg::OP_MUL_Y;
         S_DIV_Y:      cmd.op = tdf_pkg::OP_DIV_Y;
         S_FINISH:     if (status.out_free) cmd.op = tdf_pkg::OP_FINISH;
         default:      cmd.op = tdf_pkg::OP_NONE;
      endcase
   end

endmodule

`default_nettype wire

FILE: rtl/core/tdf_datapath.sv
// ----------------------------------------------------------------------------
// tdf_datapath
// Breadcrumb ring, walk registers, shared restoring divider and result
// register of the trail distance follower.
// ----------------------------------------------------------------------------
`default_nettype none

module tdf_datapath (
   input  wire                         clock,
   input  wire                         reset,
   input  tdf_pkg::cmd_type            cmd,
   output tdf_pkg::status_type         status,
   input  wire [tdf_pkg::DIST_W-1:0]   trail_distance,
   input  wire                         req_leader_valid,
   input  wire [15:0]                  req_leader_x,
   input  wire [15:0]                  req_leader_y,
   input  wire [1:0]                   req_leader_facing,
   input  wire [7:0]                   req_leader_subpriority,
   input  wire                         req_leader_hidden,
   input  wire                         req_hold_direction,
   output logic                        rsp_valid,
   input  wire                         rsp_ready,
   output logic [15:0]                 rsp_follower_x,
   output logic [15:0]                 rsp_follower_y,
   output logic [1:0]                  rsp_follower_direction,
   output logic                        rsp_moving,
   output logic [2:0]                  rsp_anim_index,
   output logic [7:0]                  rsp_subpriority,
   output logic                        rsp_invisible
);

   localparam int IW = tdf_pkg::IDX_W;
   localparam int CW = tdf_pkg::CNT_W;
   localparam int DW = tdf_pkg::DIST_W;
   localparam int MW = tdf_pkg::MAG_W;
   localparam int QW = tdf_pkg::QUOT_W;
   localparam int NW = tdf_pkg::NUM_W;
   localparam int SW = tdf_pkg::STEP_W;

   // ring storage
   logic [31:0] trail_mem [tdf_pkg::TRAIL_DEPTH];
   logic          mem_we, mem_re;
   logic [IW-1:0] mem_waddr, mem_raddr;
   logic [31:0]   mem_wdata;
   logic [31:0]   rd_q_ff;

   // captured item
   logic        lv_ff, lv_in;
   logic [15:0] lx_ff, lx_in, ly_ff, ly_in;
   logic [1:0]  face_ff, face_in;
   logic [7:0]  sub_ff, sub_in;
   logic        hid_ff, hid_in, hold_ff, hold_in;

   // persistent state
   logic [IW-1:0] head_ff, head_in;
   logic [CW-1:0] count_ff, count_in;
   logic [31:0]   last_ff, last_in;
   logic [1:0]    dir_ff, dir_in;

   // walk and divider
   logic [IW-1:0] idx_ff, idx_in;
   logic [CW-1:0] step_ff, step_in;
   logic [DW-1:0] dist_ff, dist_in, rem_ff, rem_in;
   logic [31:0]   newer_ff, newer_in, older_ff, older_in, pos_ff, pos_in;
   logic [15:0]   dx_ff, dx_in, dy_ff, dy_in;
   logic [MW-1:0] seg_ff, seg_in;
   logic [NW-1:0] num_ff, num_in;
   logic [QW-1:0] q_ff, q_in;
   logic [SW-1:0] k_ff, k_in;
   logic          neg_ff, neg_in;

   // result register
   logic        rv_ff, rv_in;
   logic [15:0] ox_ff, ox_in, oy_ff, oy_in;
   logic [1:0]  odir_ff, odir_in;
   logic        omov_ff, omov_in;
   logic [7:0]  osub_ff, osub_in;
   logic        oinv_ff, oinv_in;

   // combinational helpers
   logic [15:0]   ldx, ldy, wdx, wdy, dseed, qs, base;
   logic [17:0]   lsum, tsum;
   logic [31:0]   seed;
   logic [IW-1:0] head_nx, idx_pv;
   logic [MW-1:0] mx, my;
   logic [NW-1:0] trial;
   logic          ge, moving;
   logic [QW-1:0] q_nx;

   // log check against newest entry
   assign ldx  = lx_ff - rd_q_ff[15:0];
   assign ldy  = ly_ff - rd_q_ff[31:16];
   assign lsum = {1'b0, tdf_pkg::mag16(ldx)} + {1'b0, tdf_pkg::mag16(ldy)};

   // walk segment and hit test
   assign wdx  = rd_q_ff[15:0]  - newer_ff[15:0];
   assign wdy  = rd_q_ff[31:16] - newer_ff[31:16];
   assign tsum = 18'(dist_ff) + {1'b0, seg_ff};
   assign mx   = tdf_pkg::mag16(dx_ff);
   assign my   = tdf_pkg::mag16(dy_ff);

   // ring index wrap
   assign head_nx = (head_ff == IW'(tdf_pkg::TRAIL_DEPTH - 1)) ? '0 : head_ff + 1'b1;
   assign idx_pv  = (idx_ff == '0) ? IW'(tdf_pkg::TRAIL_DEPTH - 1) : idx_ff - 1'b1;

   // seed point one distance behind the leader
   assign dseed = 16'(trail_distance);
   always_comb begin
      seed = {ly_ff, lx_ff};
      case (face_ff)
         tdf_pkg::FACE_SOUTH: seed = {ly_ff - dseed, lx_ff};
         tdf_pkg::FACE_NORTH: seed = {ly_ff + dseed, lx_ff};
         tdf_pkg::FACE_WEST:  seed = {ly_ff, lx_ff + dseed};
         tdf_pkg::FACE_EAST:  seed = {ly_ff, lx_ff - dseed};
         default:             seed = {ly_ff, lx_ff};
      endcase
   end

   // divider step
   assign trial = NW'(seg_ff) << k_ff;
   assign ge    = (num_ff >= trial);
   assign q_nx  = {q_ff[QW-2:0], ge};
   assign qs    = neg_ff ? (16'd0 - 16'(q_nx)) : 16'(q_nx);
   assign base  = (cmd.op == tdf_pkg::OP_DIV_X) ? newer_ff[15:0] : newer_ff[31:16];
   assign moving = (pos_ff != last_ff);

   // status to the sequencer
   always_comb begin
      status.lead_valid  = lv_ff;
      status.trail_empty = (count_ff == '0);
      status.same_point  = (ldx == '0) && (ldy == '0);
      status.jump        = lsum > 18'(trail_distance >> 1);
      status.walk_done   = (step_ff >= count_ff);
      status.hit         = (tsum >= 18'(trail_distance)) && (seg_ff != '0);
      status.div_last    = (k_ff == '0);
      status.out_free    = !rv_ff || rsp_ready;
   end

   // next values
   always_comb begin
      lv_in = lv_ff;  lx_in = lx_ff;  ly_in = ly_ff;  face_in = face_ff;
      sub_in = sub_ff;  hid_in = hid_ff;  hold_in = hold_ff;
      head_in = head_ff;  count_in = count_ff;  last_in = last_ff;  dir_in = dir_ff;
      idx_in = idx_ff;  step_in = step_ff;  dist_in = dist_ff;  rem_in = rem_ff;
      newer_in = newer_ff;  older_in = older_ff;  pos_in = pos_ff;
      dx_in = dx_ff;  dy_in = dy_ff;  seg_in = seg_ff;
      num_in = num_ff;  q_in = q_ff;  k_in = k_ff;  neg_in = neg_ff;
      rv_in = rv_ff;  ox_in = ox_ff;  oy_in = oy_ff;  odir_in = odir_ff;
      omov_in = omov_ff;  osub_in = osub_ff;  oinv_in = oinv_ff;
      mem_we = 1'b0;  mem_waddr = head_nx;  mem_wdata = {ly_ff, lx_ff};
      mem_re = 1'b0;  mem_raddr = head_ff;

      // drop the delivered item
      if (rv_ff && rsp_ready) rv_in = 1'b0;

      case (cmd.op)
         tdf_pkg::OP_CAPTURE: begin
            lv_in   = req_leader_valid;
            lx_in   = req_leader_x;
            ly_in   = req_leader_y;
            face_in = req_leader_facing;
            sub_in  = req_leader_subpriority;
            hid_in  = req_leader_hidden;
            hold_in = req_hold_direction;
         end
         tdf_pkg::OP_LOG_RD: begin
            mem_re = 1'b1;
         end
         tdf_pkg::OP_LOG_WR: begin
            mem_we  = 1'b1;
            head_in = head_nx;
            if (count_ff < CW'(tdf_pkg::TRAIL_DEPTH)) count_in = count_ff + 1'b1;
         end
         tdf_pkg::OP_SEED_A: begin
            mem_we    = 1'b1;
            mem_waddr = IW'(0);
            mem_wdata = seed;
            last_in   = seed;
            dir_in    = face_ff;
         end
         tdf_pkg::OP_SEED_B: begin
            mem_we    = 1'b1;
            mem_waddr = IW'(1);
            head_in   = IW'(1);
            count_in  = CW'(2);
         end
         tdf_pkg::OP_WALK_RD: begin
            mem_re  = 1'b1;
            idx_in  = head_ff;
            step_in = CW'(1);
            dist_in = '0;
         end
         tdf_pkg::OP_WALK_NEW: begin
            newer_in = rd_q_ff;
         end
         tdf_pkg::OP_WALK_ISSUE: begin
            // out of points: sit on the oldest one reached
            if (step_ff >= count_ff) begin
               pos_in = newer_ff;
            end else begin
               mem_re    = 1'b1;
               mem_raddr = idx_pv;
               idx_in    = idx_pv;
            end
         end
         tdf_pkg::OP_WALK_SEG: begin
            older_in = rd_q_ff;
            dx_in    = wdx;
            dy_in    = wdy;
            seg_in   = tdf_pkg::mag16(wdx) + tdf_pkg::mag16(wdy);
         end
         tdf_pkg::OP_WALK_TEST: begin
            if (status.hit) begin
               rem_in = trail_distance - dist_ff;
               if (!hold_ff) begin
                  if (mx > my)           dir_in = dx_ff[15] ? tdf_pkg::FACE_EAST
                                                            : tdf_pkg::FACE_WEST;
                  else if (dy_ff != '0)  dir_in = dy_ff[15] ? tdf_pkg::FACE_SOUTH
                                                            : tdf_pkg::FACE_NORTH;
               end
            end else begin
               dist_in  = dist_ff + seg_ff[DW-1:0];
               newer_in = older_ff;
               step_in  = step_ff + 1'b1;
            end
         end
         tdf_pkg::OP_MUL_X, tdf_pkg::OP_MUL_Y: begin
            if (cmd.op == tdf_pkg::OP_MUL_X) begin
               num_in = NW'(mx) * NW'(rem_ff);
               neg_in = dx_ff[15];
            end else begin
               num_in = NW'(my) * NW'(rem_ff);
               neg_in = dy_ff[15];
            end
            q_in = '0;
            k_in = SW'(QW - 1);
         end
         tdf_pkg::OP_DIV_X, tdf_pkg::OP_DIV_Y: begin
            if (ge) num_in = num_ff - trial;
            q_in = q_nx;
            k_in = k_ff - 1'b1;
            if (k_ff == '0) begin
               if (cmd.op == tdf_pkg::OP_DIV_X) pos_in[15:0]  = base + qs;
               else                             pos_in[31:16] = base + qs;
            end
         end
         tdf_pkg::OP_FINISH: begin
            rv_in   = 1'b1;
            odir_in = dir_ff;
            if (lv_ff) begin
               last_in = pos_ff;
               ox_in   = pos_ff[15:0];
               oy_in   = pos_ff[31:16];
               omov_in = moving;
               oinv_in = hid_ff;
               osub_in = sub_ff;
               if ($signed(pos_ff[31:16]) < $signed(ly_ff) && sub_ff != 8'h00)
                  osub_in = sub_ff - 1'b1;
               else if ($signed(pos_ff[31:16]) > $signed(ly_ff) && sub_ff != 8'hFF)
                  osub_in = sub_ff + 1'b1;
            end else begin
               ox_in   = last_ff[15:0];
               oy_in   = last_ff[31:16];
               omov_in = 1'b0;
               oinv_in = 1'b1;
               osub_in = 8'h00;
            end
         end
         default: begin
         end
      endcase
   end

   // ring write and registered read
   always_ff @(posedge clock) begin
      if (mem_we) trail_mem[mem_waddr] <= mem_wdata;
      if (mem_re) rd_q_ff <= trail_mem[mem_raddr];
   end

   // control and persistent state
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
         last_ff  <= '0;
         dir_ff   <= tdf_pkg::FACE_SOUTH;
         rv_ff    <= 1'b0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
         last_ff  <= last_in;
         dir_ff   <= dir_in;
         rv_ff    <= rv_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      lv_ff <= lv_in;  lx_ff <= lx_in;  ly_ff <= ly_in;  face_ff <= face_in;
      sub_ff <= sub_in;  hid_ff <= hid_in;  hold_ff <= hold_in;
      idx_ff <= idx_in;  step_ff <= step_in;  dist_ff <= dist_in;  rem_ff <= rem_in;
      newer_ff <= newer_in;  older_ff <= older_in;  pos_ff <= pos_in;
      dx_ff <= dx_in;  dy_ff <= dy_in;  seg_ff <= seg_in;
      num_ff <= num_in;  q_ff <= q_in;  k_ff <= k_in;  neg_ff <= neg_in;
      ox_ff <= ox_in;  oy_ff <= oy_in;  odir_ff <= odir_in;
      omov_ff <= omov_in;  osub_ff <= osub_in;  oinv_ff <= oinv_in;
   end

   assign rsp_valid              = rv_ff;
   assign rsp_follower_x         = ox_ff;
   assign rsp_follower_y         = oy_ff;
   assign rsp_follower_direction = odir_ff;
   assign rsp_moving             = omov_ff;
   assign rsp_anim_index         = {omov_ff, odir_ff};
   assign rsp_subpriority        = osub_ff;
   assign rsp_invisible          = oinv_ff;

endmodule

`default_nettype wire

FILE: rtl/core/trail_distance_follower_unit.sv
// ----------------------------------------------------------------------------
// trail_distance_follower_unit
// Follower placement along a breadcrumb trail of the leader's positions.
// ----------------------------------------------------------------------------
// One req_ item per frame carries the leader's state; one rsp_ item comes
// back with the follower's position, direction, animation, subpriority and
// visibility. The trail distance register sits at byte address 0 of the
// APB-style port; the user must write it only while the unit is idle, as
// the unit itself does not enforce this.
// An invalid leader goes straight to publishing. A valid leader is logged
// or reseeds the trail, fetches the newest point, walks the ring of up to
// 64 entries entry by entry (ring read, segment, compare), runs the two
// 6-step restoring divisions once the distance is reached (none when the
// trail runs out first) and publishes; req_ready returns in the next cycle.
// One item is in work at a time; req_ready is high while the sequencer is
// idle, and the next item may be accepted while a result still waits in the
// output register. A stalled receiver holds the result and stops the
// sequencer at its publish step.
// Reset empties the trail (the next valid frame reseeds it), clears the last
// position, sets the direction to south and the trail distance to 16.
// ----------------------------------------------------------------------------
`default_nettype none

module trail_distance_follower_unit (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_ready,
   input  wire         req_leader_valid,
   input  wire  [15:0] req_leader_x,
   input  wire  [15:0] req_leader_y,
   input  wire  [1:0]  req_leader_facing,
   input  wire  [7:0]  req_leader_subpriority,
   input  wire         req_leader_hidden,
   input  wire         req_hold_direction,
   output logic        rsp_valid,
   input  wire         rsp_ready,
   output logic [15:0] rsp_follower_x,
   output logic [15:0] rsp_follower_y,
   output logic [1:0]  rsp_follower_direction,
   output logic        rsp_moving,
   output logic [2:0]  rsp_anim_index,
   output logic [7:0]  rsp_subpriority,
   output logic        rsp_invisible,
   input  wire         psel,
   input  wire         penable,
   input  wire         pwrite,
   input  wire  [2:0]  paddr,
   input  wire  [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   tdf_pkg::cmd_type    cmd;
   tdf_pkg::status_type status;

   logic [tdf_pkg::DIST_W-1:0] dist_ff, dist_in;
   logic                       csr_hit;

   // trail distance register
   assign csr_hit = (paddr[2] == tdf_pkg::REG_TRAIL_DISTANCE);
   assign pready  = 1'b1;
   assign prdata  = csr_hit ? 32'(dist_ff) : 32'd0;

   always_comb begin
      dist_in = dist_ff;
      if (psel && penable && pwrite && pready && csr_hit)
         dist_in = pwdata[tdf_pkg::DIST_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dist_ff <= tdf_pkg::DIST_RESET;
      end else begin
         dist_ff <= dist_in;
      end
   end

   tdf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   tdf_datapath u_datapath (
      .clock                  (clock),
      .reset                  (reset),
      .cmd                    (cmd),
      .status                 (status),
      .trail_distance         (dist_ff),
      .req_leader_valid       (req_leader_valid),
      .req_leader_x           (req_leader_x),
      .req_leader_y           (req_leader_y),
      .req_leader_facing      (req_leader_facing),
      .req_leader_subpriority (req_leader_subpriority),
      .req_leader_hidden      (req_leader_hidden),
      .req_hold_direction     (req_hold_direction),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_follower_x         (rsp_follower_x),
      .rsp_follower_y         (rsp_follower_y),
      .rsp_follower_direction (rsp_follower_direction),
      .rsp_moving             (rsp_moving),
      .rsp_anim_index         (rsp_anim_index),
      .rsp_subpriority        (rsp_subpriority),
      .rsp_invisible          (rsp_invisible)
   );

endmodule

`default_nettype wire
